// ----- rtl/wsfr_pkg.sv -----
// shared types and codes for the websocket frame receiver
package wsfr_pkg;

   // result kinds
   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_PING     = 3'd1;
   localparam logic [2:0] KIND_CLOSE    = 3'd2;
   localparam logic [2:0] KIND_EMPTY    = 3'd3;
   localparam logic [2:0] KIND_BAD_CONT = 3'd4;
   localparam logic [2:0] KIND_BAD_OP   = 3'd5;
   localparam logic [2:0] KIND_WIRE_END = 3'd6;

   // frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // 7-bit length escapes
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       wire_end;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload_byte;
      logic       frame_last;
      logic       message_last;
      logic       message_first;
      logic       message_is_text;
   } rsp_beat_type;

endpackage

// ----- rtl/websocket_frame_receiver.sv -----
// websocket frame receiver: header parse, unmasking and message tracking
//
// usage
//   req channel: one wire byte per beat (rx_byte), or an end-of-stream marker
//   (wire_end = 1) in place of a byte
//   rsp channel: at most one result beat per request beat, tagged by kind:
//   data, ping and close payload bytes, empty frame end, bad continuation,
//   bad opcode, wire ended; pong payloads give no beat at all
//   timing: rsp is registered; a result appears in the cycle after its beat is taken
//   throughput: one request beat per cycle while req_stall is low; parse state,
//   the 64-bit remaining-length counter and mask xor all settle combinationally
//   reset: synchronous, active high; parser waits for the first header byte,
//   no message open, link open
//   stall: rsp has a single output register; req_stall rises only while that
//   register holds a beat and rsp_stall is high, so a beat is taken in the
//   same cycle the old result leaves
//   after a close frame, a bad frame or wire end the link stays closed and
//   every request beat is taken and dropped until reset
module websocket_frame_receiver (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wsfr_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wsfr_pkg::rsp_beat_type rsp_data
);
   import wsfr_pkg::*;

   // parser phases
   localparam logic [2:0] PH_HEAD0   = 3'd0;
   localparam logic [2:0] PH_HEAD1   = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   // frame classes
   localparam logic [2:0] CL_DATA    = 3'd0;
   localparam logic [2:0] CL_PING    = 3'd1;
   localparam logic [2:0] CL_CLOSE   = 3'd2;
   localparam logic [2:0] CL_PONG    = 3'd3;
   localparam logic [2:0] CL_BADCONT = 3'd4;
   localparam logic [2:0] CL_BADOP   = 3'd5;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic        final_ff, final_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  mpos_ff, mpos_in;
   logic        msg_open_ff, msg_open_in;
   logic        msg_text_ff, msg_text_in;
   logic        first_pend_ff, first_pend_in;
   logic        closed_ff, closed_in;

   // output register
   logic         rsp_valid_ff;
   rsp_beat_type rsp_data_ff;

   logic         req_accept;
   logic         out_valid;
   rsp_beat_type out_beat;
   logic [2:0]   frame_class;
   logic [7:0]   mask_byte;
   logic [7:0]   plain;
   logic [6:0]   len7;
   logic         len_done;
   logic         key_done;
   logic         fin_go;
   logic         fin_has;
   logic [7:0]   fin_byte;

   // the output register frees up whenever its beat is taken
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // class of the frame under way, from its opcode and the message state
   always_comb begin
      case (opcode_ff)
         OP_CONT:   frame_class = msg_open_ff ? CL_DATA : CL_BADCONT;
         OP_TEXT:   frame_class = CL_DATA;
         OP_BINARY: frame_class = CL_DATA;
         OP_CLOSE:  frame_class = CL_CLOSE;
         OP_PING:   frame_class = CL_PING;
         OP_PONG:   frame_class = CL_PONG;
         default:   frame_class = CL_BADOP;
      endcase
   end

   // mask key byte for this payload position, first key byte on the wire first
   always_comb begin
      case (mpos_ff)
         2'd0:    mask_byte = key_ff[31:24];
         2'd1:    mask_byte = key_ff[23:16];
         2'd2:    mask_byte = key_ff[15:8];
         default: mask_byte = key_ff[7:0];
      endcase
   end

   assign plain = req_data.rx_byte ^ mask_byte;
   assign len7  = req_data.rx_byte[6:0];

   // next state and result for one request beat
   always_comb begin
      phase_in      = phase_ff;
      final_in      = final_ff;
      opcode_in     = opcode_ff;
      masked_in     = masked_ff;
      hcount_in     = hcount_ff;
      remain_in     = remain_ff;
      key_in        = key_ff;
      mpos_in       = mpos_ff;
      msg_open_in   = msg_open_ff;
      msg_text_in   = msg_text_ff;
      first_pend_in = first_pend_ff;
      closed_in     = closed_ff;
      out_valid     = 1'b0;
      out_beat      = '0;
      len_done      = 1'b0;
      key_done      = 1'b0;
      fin_go        = 1'b0;
      fin_has       = 1'b0;
      fin_byte      = 8'd0;

      if (!closed_ff) begin
         if (req_data.wire_end) begin
            out_valid     = 1'b1;
            out_beat.kind = KIND_WIRE_END;
            closed_in     = 1'b1;
         end else begin
            case (phase_ff)
               PH_HEAD0: begin
                  final_in  = req_data.rx_byte[7];
                  opcode_in = req_data.rx_byte[3:0];
                  if (req_data.rx_byte[3:0] inside {OP_TEXT, OP_BINARY}) begin
                     msg_open_in   = 1'b1;
                     msg_text_in   = (req_data.rx_byte[3:0] == OP_TEXT);
                     first_pend_in = 1'b1;
                  end
                  phase_in = PH_HEAD1;
               end
               PH_HEAD1: begin
                  masked_in = req_data.rx_byte[7];
                  hcount_in = 3'd0;
                  remain_in = 64'd0;
                  if (len7 == LEN_EXT16) begin
                     phase_in = PH_EXT16;
                  end else if (len7 == LEN_EXT64) begin
                     phase_in = PH_EXT64;
                  end else begin
                     remain_in = {57'd0, len7};
                     len_done  = 1'b1;
                  end
               end
               PH_EXT16, PH_EXT64: begin
                  // big-endian length; the 64-bit form ends when the count wraps
                  remain_in = {remain_ff[55:0], req_data.rx_byte};
                  hcount_in = hcount_ff + 3'd1;
                  if (hcount_in == ((phase_ff == PH_EXT16) ? 3'd2 : 3'd0)) begin
                     len_done = 1'b1;
                  end
               end
               PH_KEY: begin
                  key_in    = {key_ff[23:0], req_data.rx_byte};
                  hcount_in = hcount_ff + 3'd1;
                  if (hcount_in == 3'd4) begin
                     key_done = 1'b1;
                  end
               end
               PH_PAYLOAD: begin
                  mpos_in   = mpos_ff + 2'd1;
                  remain_in = remain_ff - 64'd1;
                  if (remain_ff == 64'd1) begin
                     fin_go   = 1'b1;
                     fin_has  = 1'b1;
                     fin_byte = plain;
                  end else begin
                     case (frame_class)
                        CL_DATA: begin
                           out_valid                = 1'b1;
                           out_beat.kind            = KIND_DATA;
                           out_beat.payload_byte    = plain;
                           out_beat.message_first   = first_pend_ff;
                           out_beat.message_is_text = msg_text_ff;
                           first_pend_in            = 1'b0;
                        end
                        CL_PING: begin
                           out_valid             = 1'b1;
                           out_beat.kind         = KIND_PING;
                           out_beat.payload_byte = plain;
                        end
                        CL_CLOSE: begin
                           out_valid             = 1'b1;
                           out_beat.kind         = KIND_CLOSE;
                           out_beat.payload_byte = plain;
                        end
                        default: begin
                           out_valid = 1'b0;
                        end
                     endcase
                  end
               end
               default: begin
                  phase_in = PH_HEAD0;
               end
            endcase

            // length complete: go for the key, or straight on without one
            if (len_done) begin
               if (masked_in) begin
                  phase_in  = PH_KEY;
                  hcount_in = 3'd0;
               end else begin
                  key_in   = 32'd0;
                  key_done = 1'b1;
               end
            end

            // key complete: payload, or an empty frame ends here
            if (key_done) begin
               if (remain_in != 64'd0) begin
                  phase_in = PH_PAYLOAD;
                  mpos_in  = 2'd0;
               end else begin
                  fin_go = 1'b1;
               end
            end

            // frame end, with its last payload byte when there is one
            if (fin_go) begin
               phase_in = PH_HEAD0;
               case (frame_class)
                  CL_DATA: begin
                     out_valid                = 1'b1;
                     out_beat.kind            = fin_has ? KIND_DATA : KIND_EMPTY;
                     out_beat.payload_byte    = fin_byte;
                     out_beat.frame_last      = 1'b1;
                     out_beat.message_last    = final_ff;
                     out_beat.message_first   = first_pend_ff;
                     out_beat.message_is_text = msg_text_ff;
                     first_pend_in            = 1'b0;
                     if (final_ff) begin
                        msg_open_in = 1'b0;
                     end
                  end
                  CL_PING: begin
                     out_valid             = 1'b1;
                     out_beat.kind         = fin_has ? KIND_PING : KIND_EMPTY;
                     out_beat.payload_byte = fin_byte;
                     out_beat.frame_last   = 1'b1;
                  end
                  CL_CLOSE: begin
                     out_valid             = 1'b1;
                     out_beat.kind         = fin_has ? KIND_CLOSE : KIND_EMPTY;
                     out_beat.payload_byte = fin_byte;
                     out_beat.frame_last   = 1'b1;
                     closed_in             = 1'b1;
                  end
                  CL_PONG: begin
                     out_valid = 1'b0;
                  end
                  CL_BADCONT: begin
                     out_valid           = 1'b1;
                     out_beat.kind       = KIND_BAD_CONT;
                     out_beat.frame_last = 1'b1;
                     closed_in           = 1'b1;
                  end
                  default: begin
                     out_valid           = 1'b1;
                     out_beat.kind       = KIND_BAD_OP;
                     out_beat.frame_last = 1'b1;
                     closed_in           = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   // parser state advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD0;
         final_ff      <= 1'b0;
         opcode_ff     <= 4'd0;
         masked_ff     <= 1'b0;
         hcount_ff     <= 3'd0;
         remain_ff     <= 64'd0;
         key_ff        <= 32'd0;
         mpos_ff       <= 2'd0;
         msg_open_ff   <= 1'b0;
         msg_text_ff   <= 1'b0;
         first_pend_ff <= 1'b0;
         closed_ff     <= 1'b0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         final_ff      <= final_in;
         opcode_ff     <= opcode_in;
         masked_ff     <= masked_in;
         hcount_ff     <= hcount_in;
         remain_ff     <= remain_in;
         key_ff        <= key_in;
         mpos_ff       <= mpos_in;
         msg_open_ff   <= msg_open_in;
         msg_text_ff   <= msg_text_in;
         first_pend_ff <= first_pend_in;
         closed_ff     <= closed_in;
      end
   end

   // output register: loads whenever the old beat is gone or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= req_accept && out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && out_valid) begin
         rsp_data_ff <= out_beat;
      end
   end

`ifndef SYNTHESIS
   // a closed link never reopens
   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("link reopened after close");

   // beats taken on a closed link produce nothing
   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && closed_ff) |=> !rsp_valid_ff)
      else $error("result produced on closed link");

   // payload phase always has bytes left to take
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != 64'd0))
      else $error("payload phase with zero length left");

   // message start flag only rides on data or empty data results
   a_first_on_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.message_first) |->
         (rsp_data_ff.kind == KIND_DATA || rsp_data_ff.kind == KIND_EMPTY))
      else $error("message_first on non-data result");
`endif

endmodule

// ----- tb/ws_frame_checker.sv -----
// scoreboard for the websocket frame receiver: predicts every result beat and checks it
module ws_frame_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  wsfr_pkg::req_beat_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  wsfr_pkg::rsp_beat_type rsp_data,
   output int                     fail_count,
   output int                     pending_results
);
   import wsfr_pkg::*;

   typedef enum logic [2:0] {
      AWAIT_HDR, AWAIT_LEN, EXT_LEN16, EXT_LEN64, MASK_KEY_BYTES, PAYLOAD_BYTES
   } parse_phase_type;

   typedef enum logic [2:0] {
      CLS_DATA, CLS_PING, CLS_CLOSE, CLS_PONG, CLS_BAD_CONT, CLS_BAD_OP
   } frame_class_type;

   // parser state
   parse_phase_type phase;
   logic         fin_bit;
   logic [3:0]   opcode;
   logic         masked;
   logic [2:0]   hdr_cnt;
   logic [63:0]  remaining;
   logic [31:0]  key;
   logic [1:0]   key_pos;
   logic         msg_open;
   logic         msg_text;
   logic         first_due;
   logic         closed;

   rsp_beat_type parsed_q[$];
   int           mismatches = 0;
   int           queued = 0;
   int           checked = 0;

   assign fail_count      = mismatches;
   assign pending_results = queued;

   function automatic frame_class_type classify_frame();
      case (opcode)
         OP_CONT:            return msg_open ? CLS_DATA : CLS_BAD_CONT;
         OP_TEXT, OP_BINARY: return CLS_DATA;
         OP_CLOSE:           return CLS_CLOSE;
         OP_PING:            return CLS_PING;
         OP_PONG:            return CLS_PONG;
         default:            return CLS_BAD_OP;
      endcase
   endfunction

   // frame completion, carrying the last payload byte when there is one
   function automatic bit end_of_frame(input bit has_byte, input logic [7:0] plain,
                                       output rsp_beat_type res);
      frame_class_type cls;
      cls = classify_frame();
      res = '0;
      res.frame_last = 1'b1;
      phase = AWAIT_HDR;
      case (cls)
         CLS_DATA: begin
            res.kind            = has_byte ? KIND_DATA : KIND_EMPTY;
            res.payload_byte    = has_byte ? plain : 8'h00;
            res.message_last    = fin_bit;
            res.message_first   = first_due;
            res.message_is_text = msg_text;
            first_due = 1'b0;
            if (fin_bit) msg_open = 1'b0;
            return 1'b1;
         end
         CLS_PING: begin
            res.kind         = has_byte ? KIND_PING : KIND_EMPTY;
            res.payload_byte = has_byte ? plain : 8'h00;
            return 1'b1;
         end
         CLS_CLOSE: begin
            res.kind         = has_byte ? KIND_CLOSE : KIND_EMPTY;
            res.payload_byte = has_byte ? plain : 8'h00;
            closed = 1'b1;
            return 1'b1;
         end
         CLS_PONG: return 1'b0;
         CLS_BAD_CONT: begin
            res.kind = KIND_BAD_CONT;
            closed = 1'b1;
            return 1'b1;
         end
         default: begin
            res.kind = KIND_BAD_OP;
            closed = 1'b1;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic bit after_key(output rsp_beat_type res);
      res = '0;
      if (remaining != 64'd0) begin
         phase   = PAYLOAD_BYTES;
         key_pos = 2'd0;
         return 1'b0;
      end
      return end_of_frame(1'b0, 8'h00, res);
   endfunction

   function automatic bit after_length(output rsp_beat_type res);
      res = '0;
      if (masked) begin
         phase   = MASK_KEY_BYTES;
         hdr_cnt = 3'd0;
         return 1'b0;
      end
      key = '0;
      return after_key(res);
   endfunction

   // one wire beat in, at most one result out
   function automatic bit parse_wire_beat(input req_beat_type beat, output rsp_beat_type res);
      logic [7:0] plain;
      res = '0;
      if (closed) return 1'b0;
      if (beat.wire_end) begin
         res.kind = KIND_WIRE_END;
         closed = 1'b1;
         return 1'b1;
      end
      case (phase)
         AWAIT_HDR: begin
            fin_bit = beat.rx_byte[7];
            opcode  = beat.rx_byte[3:0];
            if (opcode == OP_TEXT || opcode == OP_BINARY) begin
               msg_open  = 1'b1;
               msg_text  = (opcode == OP_TEXT);
               first_due = 1'b1;
            end
            phase = AWAIT_LEN;
            return 1'b0;
         end
         AWAIT_LEN: begin
            masked    = beat.rx_byte[7];
            hdr_cnt   = 3'd0;
            remaining = '0;
            if (beat.rx_byte[6:0] == LEN_EXT16) begin
               phase = EXT_LEN16;
               return 1'b0;
            end
            if (beat.rx_byte[6:0] == LEN_EXT64) begin
               phase = EXT_LEN64;
               return 1'b0;
            end
            remaining = 64'(beat.rx_byte[6:0]);
            return after_length(res);
         end
         EXT_LEN16, EXT_LEN64: begin
            remaining = {remaining[55:0], beat.rx_byte};
            hdr_cnt   = hdr_cnt + 3'd1;
            // eight length bytes wrap the 3-bit count back to zero
            if (hdr_cnt == ((phase == EXT_LEN16) ? 3'd2 : 3'd0)) return after_length(res);
            return 1'b0;
         end
         MASK_KEY_BYTES: begin
            key     = {key[23:0], beat.rx_byte};
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt == 3'd4) return after_key(res);
            return 1'b0;
         end
         PAYLOAD_BYTES: begin
            plain     = beat.rx_byte ^ key[8*(3-key_pos) +: 8];
            key_pos   = key_pos + 2'd1;
            remaining = remaining - 64'd1;
            if (remaining == 64'd0) return end_of_frame(1'b1, plain, res);
            case (classify_frame())
               CLS_DATA: begin
                  res.kind            = KIND_DATA;
                  res.payload_byte    = plain;
                  res.message_first   = first_due;
                  res.message_is_text = msg_text;
                  first_due = 1'b0;
                  return 1'b1;
               end
               CLS_PING: begin
                  res.kind         = KIND_PING;
                  res.payload_byte = plain;
                  return 1'b1;
               end
               CLS_CLOSE: begin
                  res.kind         = KIND_CLOSE;
                  res.payload_byte = plain;
                  return 1'b1;
               end
               default: return 1'b0;
            endcase
         end
         default: begin
            phase = AWAIT_HDR;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic string beat_text(input rsp_beat_type b);
      return $sformatf("kind=%0d byte=%02h fl=%0b ml=%0b mf=%0b txt=%0b", b.kind,
                       b.payload_byte, b.frame_last, b.message_last, b.message_first,
                       b.message_is_text);
   endfunction

   always @(posedge clock) begin : monitor
      rsp_beat_type want;
      rsp_beat_type got;
      if (reset) begin
         phase     = AWAIT_HDR;
         fin_bit   = 1'b0;
         opcode    = '0;
         masked    = 1'b0;
         hdr_cnt   = '0;
         remaining = '0;
         key       = '0;
         key_pos   = '0;
         msg_open  = 1'b0;
         msg_text  = 1'b0;
         first_due = 1'b0;
         closed    = 1'b0;
         parsed_q.delete();
      end else begin
         // retire the older expectation before queueing this edge's new one
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (parsed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d unexpected: got %s", checked, beat_text(rsp_data));
            end else begin
               want = parsed_q.pop_front();
               if (rsp_data.kind !== want.kind ||
                   rsp_data.payload_byte !== want.payload_byte ||
                   rsp_data.frame_last !== want.frame_last ||
                   rsp_data.message_last !== want.message_last ||
                   rsp_data.message_first !== want.message_first ||
                   rsp_data.message_is_text !== want.message_is_text) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d mismatch: expected %s, got %s", checked,
                              beat_text(want), beat_text(rsp_data));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (parse_wire_beat(req_data, got)) parsed_q.push_back(got);
         end
      end
      queued = parsed_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// top of the websocket frame receiver testbench: wire byte stimulus, stall control, verdict
module tb_top;
   import wsfr_pkg::*;

   // random stimulus length and run guards
   localparam int RANDOM_BEATS   = 1000;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   // how a frame carries its payload length
   typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_type;

   // how the one connection of the run is brought down
   typedef enum int {END_CLOSE, END_BAD_CONT, END_BAD_OP, END_WIRE} link_end_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   req_beat_type req_data = '0;
   logic         req_stall;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;

   int fail_count;
   int pending_results;

   // traffic shaping, read by the sender task and the receiver process
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_request = 1'b0;
   int   hold_left = 0;

   int   beats_sent = 0;
   int   idle_cycles = 0;
   // mirrors whether a text/binary message is still open, so that
   // continuations are only sent where the block accepts them
   bit   msg_active = 1'b0;

   always #5 clock = ~clock;

   websocket_frame_receiver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ws_frame_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // receiver side: random stall, or a long counted hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // watchdog: ends the run once no beat has moved for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one wire beat and hold it until taken; valid stays high on return
   // so back-to-back beats only drop it in between where an idle gap is drawn
   task automatic push_wire(input logic [7:0] b, input logic end_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: b, wire_end: end_flag};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // one frame on the wire: header, length, optional key, then 'sent' random
   // payload bytes (fewer than len only for a frame cut short by wire end)
   task automatic send_frame(input logic [3:0] op, input logic fin, input logic masked,
                             input len_form_type form, input logic [63:0] len,
                             input int sent, input logic [31:0] mask_key);
      int i;
      // reserved bits go out random, the block does not check them
      push_wire({fin, 3'($urandom_range(7)), op}, 1'b0);
      case (form)
         LEN_SHORT: push_wire({masked, len[6:0]}, 1'b0);
         LEN_16: begin
            push_wire({masked, LEN_EXT16}, 1'b0);
            push_wire(len[15:8], 1'b0);
            push_wire(len[7:0], 1'b0);
         end
         default: begin
            push_wire({masked, LEN_EXT64}, 1'b0);
            for (i = 7; i >= 0; i--) push_wire(len[8*i +: 8], 1'b0);
         end
      endcase
      if (masked) begin
         for (i = 3; i >= 0; i--) push_wire(mask_key[8*i +: 8], 1'b0);
      end
      for (i = 0; i < sent; i++) push_wire(8'($urandom), 1'b0);
   endtask

   // well-formed frame with random content; never closes the link
   task automatic send_random_frame();
      int           pick;
      logic [3:0]   op;
      logic         fin;
      len_form_type form;
      logic [63:0]  len;
      pick = $urandom_range(99);
      fin  = 1'($urandom_range(1));
      if (pick < 15) op = OP_PING;
      else if (pick < 25) op = OP_PONG;
      else if (msg_active && pick < 60) op = OP_CONT;
      else op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
      // mostly short payloads; non-minimal extended lengths and the odd long
      // one, control frames included
      pick = $urandom_range(99);
      if (pick < 72) begin
         form = LEN_SHORT;
         len  = 64'($urandom_range(12));
      end else if (pick < 77) begin
         form = LEN_SHORT;
         len  = 64'($urandom_range(125, 13));
      end else if (pick < 89) begin
         form = LEN_16;
         len  = 64'($urandom_range(20));
      end else if (pick < 97) begin
         form = LEN_64;
         len  = 64'($urandom_range(20));
      end else begin
         form = LEN_16;
         len  = 64'($urandom_range(300, 126));
      end
      send_frame(op, fin, ($urandom_range(99) < 70), form, len, int'(len), $urandom);
      if (op == OP_TEXT || op == OP_BINARY) msg_active = !fin;
      else if (op == OP_CONT && fin) msg_active = 1'b0;
   endtask

   initial begin : stimulus
      int          idle_plan[4];
      int          stall_plan[4];
      int          p;
      int          i;
      int          start_beats;
      logic [3:0]  bad_op;
      idle_plan  = '{0, 82, 0, 7};
      stall_plan = '{0, 0, 82, 7};

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: text message opened by hand so the payload spans 00 and ff
      push_wire({1'b0, 3'b000, OP_TEXT}, 1'b0);
      push_wire({1'b0, 7'd2}, 1'b0);
      push_wire(8'h00, 1'b0);
      push_wire(8'hFF, 1'b0);
      // new text message while one is open, empty with fin: restart plus empty frame end
      send_frame(OP_TEXT, 1'b1, 1'b0, LEN_SHORT, 64'd0, 0, '0);
      // masked binary with an all-ones key, left open for a continuation
      send_frame(OP_BINARY, 1'b0, 1'b1, LEN_SHORT, 64'd1, 1, 32'hFFFF_FFFF);
      // empty ping, and a pong whose byte must vanish
      send_frame(OP_PING, 1'b1, 1'b0, LEN_SHORT, 64'd0, 0, '0);
      send_frame(OP_PONG, 1'b1, 1'b0, LEN_SHORT, 64'd1, 1, '0);
      // continuation closing the message, non-minimal 16-bit length
      send_frame(OP_CONT, 1'b1, 1'b0, LEN_16, 64'd1, 1, '0);
      msg_active = 1'b0;

      // random part in four traffic phases: free flow, sparse sender,
      // heavy receiver stall, light jitter on both sides
      start_beats = beats_sent;
      for (p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct     = stall_plan[p];
         if (p == 0) begin
            // long receiver hold-off while a steady frame keeps coming, so the
            // output register fills and the block pushes back on req
            hold_request <= 1'b1;
            send_frame(OP_BINARY, 1'b1, 1'b0, LEN_SHORT, 64'd60, 60, '0);
            msg_active = 1'b0;
         end
         while (beats_sent < start_beats + (p + 1) * RANDOM_BEATS / 4) send_random_frame();
      end

      // the link closes for good; one way to end it is picked per run
      case (link_end_type'($urandom_range(3)))
         END_CLOSE: begin
            i = $urandom_range(5);
            send_frame(OP_CLOSE, 1'b1, 1'($urandom_range(1)), LEN_SHORT, 64'(i), i,
                       $urandom);
         end
         END_BAD_CONT: begin
            if (msg_active) send_frame(OP_CONT, 1'b1, 1'b0, LEN_SHORT, 64'd2, 2, '0);
            msg_active = 1'b0;
            i = $urandom_range(4);
            send_frame(OP_CONT, 1'($urandom_range(1)), 1'($urandom_range(1)), LEN_SHORT,
                       64'(i), i, $urandom);
         end
         END_BAD_OP: begin
            do bad_op = 4'($urandom_range(15));
            while (bad_op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
            i = $urandom_range(4);
            send_frame(bad_op, 1'($urandom_range(1)), 1'($urandom_range(1)), LEN_SHORT,
                       64'(i), i, $urandom);
         end
         default: begin
            // wire end either between frames or inside a frame of maximal length
            if ($urandom_range(1))
               send_frame(OP_BINARY, 1'b0, 1'b1, LEN_64, '1, 5, $urandom);
            push_wire(8'($urandom), 1'b1);
         end
      endcase

      // closed link: everything from here on is taken and dropped
      push_wire(8'($urandom), 1'b1);
      for (i = 0; i < 20; i++) push_wire(8'($urandom), 1'($urandom_range(1)));

      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      // after the queue drains, wait on to catch stray results
      repeat (5) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
